[rtl/fvn_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fvn_pkg
// Shared types and constants for the fractal value noise block.
// ----------------------------------------------------------------------------
package fvn_pkg;

  localparam int MAX_OCTAVES = 8;
  localparam int OCT_W       = $clog2(MAX_OCTAVES + 1);

  localparam logic [2:0] REG_OCTAVE_COUNT   = 3'd0;
  localparam logic [2:0] REG_PERSISTENCE    = 3'd1;
  localparam logic [2:0] REG_BASE_X_FREQ    = 3'd2;
  localparam logic [2:0] REG_BASE_Y_FREQ    = 3'd3;
  localparam logic [2:0] REG_BASE_AMPLITUDE = 3'd4;

  localparam logic [31:0] HASH_MUL_Y   = 32'd57;
  localparam logic [31:0] HASH_K1      = 32'd15731;
  localparam logic [31:0] HASH_K2      = 32'd789221;
  localparam logic [31:0] HASH_K3      = 32'd1376312589;
  localparam logic [31:0] FP_ONE       = 32'd65536;

  typedef struct packed {
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] noise_value;
    logic               zero_weight;
  } noise_t;

  // shared multiplier operation select
  localparam logic [1:0] MUL_FIX  = 2'd0;  // signed, asr 16
  localparam logic [1:0] MUL_WRAP = 2'd1;  // low 32 bits

endpackage
`default_nettype wire

[rtl/fvn_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fvn_div
// Radix-2 restoring signed divider, 48-bit dividend by 32-bit divisor,
// one quotient bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module fvn_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] num_hi,
  input  wire logic signed [31:0] den,
  output logic                    done,
  output logic             [31:0] quot
);
  import fvn_pkg::*;

  logic [47:0] dvd;
  logic [31:0] dsr;
  logic [32:0] rem;
  logic [5:0]  cnt;
  logic        neg;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem[31:0], dvd[47]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        rem  <= '0;
        neg  <= num_hi[31] ^ den[31];
        dvd  <= num_hi[31] ? -{num_hi, 16'h0} : {num_hi, 16'h0};
        dsr  <= den[31] ? -den : den;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          dvd <= {dvd[46:0], 1'b1};
        end else begin
          rem <= {rem[31:0], dvd[47]};
          dvd <= {dvd[46:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = neg ? -dvd[31:0] : dvd[31:0];

endmodule
`default_nettype wire

[rtl/fractal_value_noise_2d.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fractal_value_noise_2d
// Fractal 2-D value noise over up to eight octaves.
//
// A sample beat on in_* carries a signed 16.16 coordinate pair. One
// result beat on out_* carries the normalized noise and a zero-weight
// flag. cfg_* writes a register by index; write only while idle.
// One 32x32 multiplier is shared under a sequencer: amplitude setup, then
// each octave (two coordinate scales, four corner hashes of four multiplies
// each, three blends, one weighting, one amplitude step), and a serial
// divider then yields the result beat. A zero amplitude sum skips the
// divider.
// in_stall is high from acceptance until the result is taken. While
// out_stall is high the result holds.
// Synchronous reset restores the register defaults and idles the block.
// ----------------------------------------------------------------------------
module fractal_value_noise_2d (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire fvn_pkg::sample_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output fvn_pkg::noise_t       out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [31:0]      cfg_data
);
  import fvn_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_OCT  = 3'd2;
  localparam logic [2:0] S_DIVS = 3'd3;
  localparam logic [2:0] S_DIVW = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [3:0]  octave_count;
  logic [17:0] persistence;
  logic [30:0] base_x_freq, base_y_freq, base_amplitude;

  logic [2:0]  state;
  logic [4:0]  step;
  logic [OCT_W-1:0] oct, oct_lim;
  logic [31:0] xc, yc, xf, yf, amp, total, wsum;
  logic [31:0] sx, sy, ix, iy, n, t, c00, c10, c01, c11, lo, hi;
  logic [1:0]  corner;

  logic [31:0] ma, mb;
  logic [1:0]  mop;
  logic signed [63:0] prod;
  logic [31:0] mres;

  logic        div_start, div_done;
  logic [31:0] div_q;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count   <= 4'd4;
      persistence    <= 18'd32768;
      base_x_freq    <= 31'd65536;
      base_y_freq    <= 31'd65536;
      base_amplitude <= 31'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OCTAVE_COUNT:   octave_count   <= cfg_data[3:0];
        REG_PERSISTENCE:    persistence    <= cfg_data[17:0];
        REG_BASE_X_FREQ:    base_x_freq    <= cfg_data[30:0];
        REG_BASE_Y_FREQ:    base_y_freq    <= cfg_data[30:0];
        REG_BASE_AMPLITUDE: base_amplitude <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // corner coordinates
  logic [31:0] cx, cy;
  assign cx = ix + {31'd0, corner[0]};
  assign cy = iy + {31'd0, corner[1]};

  // operand selection for the shared multiplier
  always_comb begin
    ma  = '0;
    mb  = '0;
    mop = MUL_FIX;
    if (state == S_INIT) begin
      ma = {1'b0, base_amplitude};
      mb = {14'd0, persistence};
    end else begin
      case (step)
        5'd0:  begin ma = xc; mb = xf; end
        5'd1:  begin ma = yc; mb = yf; end
        5'd2:  begin ma = cy; mb = HASH_MUL_Y; mop = MUL_WRAP; end
        5'd3:  begin ma = n; mb = n; mop = MUL_WRAP; end
        5'd4:  begin ma = t; mb = HASH_K1; mop = MUL_WRAP; end
        5'd5:  begin ma = n; mb = t + HASH_K2; mop = MUL_WRAP; end
        5'd6:  begin ma = c10 - c00; mb = {16'd0, sx[15:0]}; end
        5'd7:  begin ma = c11 - c01; mb = {16'd0, sx[15:0]}; end
        5'd8:  begin ma = hi - lo; mb = {16'd0, sy[15:0]}; end
        5'd9:  begin ma = t; mb = amp; end
        5'd10: begin ma = amp; mb = {14'd0, persistence}; end
        default: ;
      endcase
    end
  end

  assign prod = $signed(ma) * $signed(mb);
  assign mres = (mop == MUL_FIX) ? prod[47:16] : prod[31:0];

  logic [31:0] nh;
  assign nh = (cx + mres) ^ ((cx + mres) << 13);

  logic [31:0] hash_v;
  logic [31:0] hfin;
  assign hfin   = (mres + HASH_K3) & 32'h7fffffff;
  assign hash_v = FP_ONE - {14'd0, hfin[31:14]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          xc <= in_data.x_coord;
          yc <= in_data.y_coord;
          state <= S_INIT;
        end
        S_INIT: begin
          amp   <= mres;
          xf    <= {base_x_freq, 1'b0};
          yf    <= {base_y_freq, 1'b0};
          total <= '0;
          wsum  <= '0;
          oct   <= '0;
          oct_lim <= (octave_count > 4'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES)
                                                    : OCT_W'(octave_count);
          state <= (octave_count == 4'd0) ? S_DIVS : S_OCT;
          step  <= 5'd0;
        end
        S_OCT: begin
          case (step)
            5'd0: begin sx <= mres; ix <= {{16{mres[31]}}, mres[31:16]}; step <= 5'd1; end
            5'd1: begin
              sy <= mres; iy <= {{16{mres[31]}}, mres[31:16]};
              corner <= 2'd0; step <= 5'd2;
            end
            5'd2: begin n <= nh; step <= 5'd3; end
            5'd3: begin t <= mres; step <= 5'd4; end
            5'd4: begin t <= mres; step <= 5'd5; end
            5'd5: begin
              case (corner)
                2'd0: c00 <= hash_v;
                2'd1: c10 <= hash_v;
                2'd2: c01 <= hash_v;
                default: c11 <= hash_v;
              endcase
              corner <= corner + 2'd1;
              step <= (corner == 2'd3) ? 5'd6 : 5'd2;
            end
            5'd6: begin lo <= mres + c00; step <= 5'd7; end
            5'd7: begin hi <= mres + c01; step <= 5'd8; end
            5'd8: begin t <= mres + lo; step <= 5'd9; end
            5'd9: begin total <= total + mres; wsum <= wsum + amp; step <= 5'd10; end
            default: begin
              amp <= mres;
              xf  <= {xf[30:0], 1'b0};
              yf  <= {yf[30:0], 1'b0};
              step <= 5'd0;
              oct <= oct + OCT_W'(1);
              if (oct + OCT_W'(1) == oct_lim) state <= S_DIVS;
            end
          endcase
        end
        S_DIVS: state <= (wsum == 32'd0) ? S_OUT : S_DIVW;
        S_DIVW: if (div_done) state <= S_OUT;
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign div_start = (state == S_DIVS) && (wsum != 32'd0);

  fvn_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num_hi (total),
    .den    (wsum),
    .done   (div_done),
    .quot   (div_q)
  );

  logic [31:0] res;
  logic        zw;
  always_ff @(posedge clk) begin
    if (state == S_DIVS) begin
      zw  <= (wsum == 32'd0);
      res <= '0;
    end else if (state == S_DIVW && div_done) begin
      res <= div_q;
    end
  end

  assign out_data.noise_value = res;
  assign out_data.zero_weight = zw;

endmodule
`default_nettype wire

[rtl/fvn_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fvn_checker
// Port-level checks for the fractal value noise block.
// ----------------------------------------------------------------------------
module fvn_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            in_valid,
  input wire logic            in_stall,
  input wire logic            out_valid,
  input wire logic            out_stall,
  input wire fvn_pkg::noise_t out_data
);
  import fvn_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_weight |-> out_data.noise_value == 32'sd0)
    else $error("zero weight with nonzero value");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall && !out_valid)
    else $error("no work after accept");

endmodule

bind fractal_value_noise_2d fvn_checker u_fvn_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
